### rtl/lbf_pkg.sv
// ----------------------------------------------------------------------------
// Learning bridge forwarder package
// Shared types, constants and the flood mask function of the bridge.
// ----------------------------------------------------------------------------
package lbf_pkg;

   // Fixed widths of the frame header and result fields.
   localparam int HOST_ADDRESS_WIDTH = 16;
   localparam int PORT_ID_WIDTH      = 3;
   localparam int MASK_WIDTH         = 8;
   localparam int COUNT_WIDTH        = 4;

   // Number of physical ports the flood range may reach.
   localparam logic [COUNT_WIDTH-1:0] PORT_NUMBER = 4'd8;
   localparam logic [COUNT_WIDTH-1:0] FLOOD_MAX   = (PORT_NUMBER < 4'(MASK_WIDTH)) ?
                                                    PORT_NUMBER : 4'(MASK_WIDTH);

   // Configuration register reset values.
   localparam logic [MASK_WIDTH-1:0]  PORT_ENABLE_RESET = 8'hFF;
   localparam logic [COUNT_WIDTH-1:0] PORT_COUNT_RESET  = 4'd8;

   // Control register bus.
   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 32;

   // Register select, taken from the word address bit of the bus.
   typedef enum logic {
      CSR_PORT_ENABLE = 1'b0,
      CSR_PORT_COUNT  = 1'b1
   } csr_sel_type;

   // One address table entry: a valid flag and the learned port.
   typedef struct packed {
      logic                     valid;
      logic [PORT_ID_WIDTH-1:0] port;
   } entry_type;

   localparam int ENTRY_WIDTH = $bits(entry_type);

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;    // latch the header of an accepted transfer, start the read
      logic clear_wr;   // write an invalid entry at the clearing address
      logic learn_wr;   // write the source address entry
      logic load_rsp;   // load the result register
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic clear_last; // clearing address points at the last entry
      logic rsp_free;   // result register can take a new result this cycle
   } status_type;

   // Flood to every enabled port below the clamped port count, except ingress.
   function automatic logic [MASK_WIDTH-1:0] flood_mask(
      input logic [MASK_WIDTH-1:0]    enable,
      input logic [COUNT_WIDTH-1:0]   count,
      input logic [PORT_ID_WIDTH-1:0] ingress
   );
      logic [COUNT_WIDTH-1:0] limit;
      logic [MASK_WIDTH-1:0]  mask;
      limit = (count < FLOOD_MAX) ? count : FLOOD_MAX;
      for (int i = 0; i < MASK_WIDTH; i++) begin
         mask[i] = (COUNT_WIDTH'(i) < limit) && (PORT_ID_WIDTH'(i) != ingress) && enable[i];
      end
      return mask;
   endfunction

endpackage

### rtl/lbf_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lbf_ram #(
   parameter int DATA_BITS = 4,
   parameter int ADDR_BITS = 16
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [DATA_BITS-1:0] wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [DATA_BITS-1:0] rd_data
);

   localparam int DEPTH = 2 ** ADDR_BITS;

   logic [DATA_BITS-1:0] mem_ff [DEPTH];
   logic [DATA_BITS-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port; the data holds while no read is issued.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/lbf_ctrl.sv
// ----------------------------------------------------------------------------
// Learning bridge forwarder controller
// Sequences the table clearing pass, header acceptance and table lookup.
// ----------------------------------------------------------------------------
module lbf_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  lbf_pkg::status_type status,
   output lbf_pkg::cmd_type    cmd
);

   import lbf_pkg::*;

   typedef enum logic [2:0] {
      ST_CLEAR  = 3'b001,
      ST_IDLE   = 3'b010,
      ST_LOOKUP = 3'b100
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   // Headers are taken only while idle.
   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && (state_ff == ST_IDLE);

   // Next state and command decode.
   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_wr = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               cmd.capture = 1'b1;
               state_in    = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            // The lookup data holds until the result register frees up.
            if (status.rsp_free) begin
               cmd.learn_wr = 1'b1;
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### rtl/lbf_datapath.sv
// ----------------------------------------------------------------------------
// Learning bridge forwarder datapath
// Control registers, address table, forwarding decision and result register.
// ----------------------------------------------------------------------------
module lbf_datapath #(
   parameter int ADDRESS_BITS = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  lbf_pkg::cmd_type                       cmd,
   output lbf_pkg::status_type                    status,
   input  logic [lbf_pkg::HOST_ADDRESS_WIDTH-1:0] req_source_address,
   input  logic [lbf_pkg::HOST_ADDRESS_WIDTH-1:0] req_destination_address,
   input  logic [lbf_pkg::PORT_ID_WIDTH-1:0]      req_ingress_port,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [lbf_pkg::MASK_WIDTH-1:0]         rsp_egress_mask,
   output logic                                   rsp_flooded,
   input  logic                                   csr_psel,
   input  logic                                   csr_penable,
   input  logic                                   csr_pwrite,
   input  logic [lbf_pkg::CSR_ADDR_WIDTH-1:0]     csr_paddr,
   input  logic [lbf_pkg::CSR_DATA_WIDTH-1:0]     csr_pwdata,
   output logic [lbf_pkg::CSR_DATA_WIDTH-1:0]     csr_prdata,
   output logic                                   csr_pready
);

   import lbf_pkg::*;

   logic [MASK_WIDTH-1:0]    port_enable_ff;
   logic [COUNT_WIDTH-1:0]   port_count_ff;
   csr_sel_type              csr_sel;
   logic                     csr_write;

   logic [ADDRESS_BITS-1:0]  clear_addr_ff;
   logic [ADDRESS_BITS-1:0]  src_ff;
   logic [PORT_ID_WIDTH-1:0] ingress_ff;

   logic                     ram_wr_en;
   logic [ADDRESS_BITS-1:0]  ram_wr_addr;
   entry_type                ram_wr_data;
   entry_type                lookup;

   logic                     rsp_valid_ff;
   logic [MASK_WIDTH-1:0]    rsp_egress_mask_ff;
   logic                     rsp_flooded_ff;
   logic [MASK_WIDTH-1:0]    mask_in;

   // Control register access; the word address bit selects the register.
   assign csr_pready = 1'b1;
   assign csr_sel    = csr_sel_type'(csr_paddr[2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         port_enable_ff <= PORT_ENABLE_RESET;
         port_count_ff  <= PORT_COUNT_RESET;
      end else if (csr_write) begin
         unique case (csr_sel)
            CSR_PORT_ENABLE: port_enable_ff <= csr_pwdata[MASK_WIDTH-1:0];
            CSR_PORT_COUNT:  port_count_ff  <= csr_pwdata[COUNT_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_sel)
         CSR_PORT_ENABLE: csr_prdata = CSR_DATA_WIDTH'(port_enable_ff);
         CSR_PORT_COUNT:  csr_prdata = CSR_DATA_WIDTH'(port_count_ff);
         default:         csr_prdata = '0;
      endcase
   end

   // Clearing address walks the whole table once after reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         clear_addr_ff <= '0;
      end else if (cmd.clear_wr) begin
         clear_addr_ff <= clear_addr_ff + 1'b1;
      end
   end

   assign status.clear_last = (clear_addr_ff == {ADDRESS_BITS{1'b1}});

   // Header fields kept for the learning write.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         src_ff     <= req_source_address[ADDRESS_BITS-1:0];
         ingress_ff <= req_ingress_port;
      end
   end

   // Table write port: clearing pass or source address learning.
   assign ram_wr_en   = cmd.clear_wr || cmd.learn_wr;
   assign ram_wr_addr = cmd.clear_wr ? clear_addr_ff : src_ff;
   always_comb begin
      if (cmd.clear_wr) begin
         ram_wr_data = '0;
      end else begin
         ram_wr_data.valid = 1'b1;
         ram_wr_data.port  = ingress_ff;
      end
   end

   lbf_ram #(
      .DATA_BITS (ENTRY_WIDTH),
      .ADDR_BITS (ADDRESS_BITS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (cmd.capture),
      .rd_addr (req_destination_address[ADDRESS_BITS-1:0]),
      .rd_data (lookup)
   );

   // Forwarding decision: learned port, or flood.
   always_comb begin
      if (lookup.valid) begin
         mask_in = MASK_WIDTH'(1) << lookup.port;
      end else begin
         mask_in = flood_mask(port_enable_ff, port_count_ff, ingress_ff);
      end
   end

   // Result register parts the lookup from a stalled receiver.
   assign status.rsp_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_egress_mask_ff <= mask_in;
         rsp_flooded_ff     <= !lookup.valid;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_egress_mask = rsp_egress_mask_ff;
   assign rsp_flooded     = rsp_flooded_ff;

endmodule

### rtl/learning_bridge_forwarder_unit.sv
// ----------------------------------------------------------------------------
// Learning bridge forwarder
// Address table lookup, flood decision and source learning for one header.
// ----------------------------------------------------------------------------
// Usage:
// A frame header (source address, destination address, ingress port) is
// taken on the req_ channel when req_valid is high and req_stall is low.
// Each header yields one transfer on the rsp_ channel: the egress port mask
// and a flag that is set when the destination was unknown and flooded.
// The destination is read from the address table on the accepting edge;
// once the result register can take it, the decision is registered and
// the source address is learned at the ingress port. A new header is not
// taken until the one before has been registered, since the single table
// is read and then written for each header.
// After reset the table is cleared one entry a cycle, with req_stall held
// high; control registers can be written then.
// While rsp_stall holds a result, the next header is still accepted and
// its lookup waits until the result register frees up.
// Registers: port_enable at byte address 0, port_count at byte address 4.
// ----------------------------------------------------------------------------
module learning_bridge_forwarder_unit #(
   parameter int ADDRESS_BITS = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [lbf_pkg::HOST_ADDRESS_WIDTH-1:0] req_source_address,
   input  logic [lbf_pkg::HOST_ADDRESS_WIDTH-1:0] req_destination_address,
   input  logic [lbf_pkg::PORT_ID_WIDTH-1:0]      req_ingress_port,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [lbf_pkg::MASK_WIDTH-1:0]         rsp_egress_mask,
   output logic                                   rsp_flooded,
   input  logic                                   csr_psel,
   input  logic                                   csr_penable,
   input  logic                                   csr_pwrite,
   input  logic [lbf_pkg::CSR_ADDR_WIDTH-1:0]     csr_paddr,
   input  logic [lbf_pkg::CSR_DATA_WIDTH-1:0]     csr_pwdata,
   output logic [lbf_pkg::CSR_DATA_WIDTH-1:0]     csr_prdata,
   output logic                                   csr_pready
);

   import lbf_pkg::*;

   cmd_type    cmd;
   status_type status;

   // Sequencer.
   lbf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // Table, registers and decision logic.
   lbf_datapath #(
      .ADDRESS_BITS (ADDRESS_BITS)
   ) u_datapath (
      .clock                   (clock),
      .reset                   (reset),
      .cmd                     (cmd),
      .status                  (status),
      .req_source_address      (req_source_address),
      .req_destination_address (req_destination_address),
      .req_ingress_port        (req_ingress_port),
      .rsp_valid               (rsp_valid),
      .rsp_stall               (rsp_stall),
      .rsp_egress_mask         (rsp_egress_mask),
      .rsp_flooded             (rsp_flooded),
      .csr_psel                (csr_psel),
      .csr_penable             (csr_penable),
      .csr_pwrite              (csr_pwrite),
      .csr_paddr               (csr_paddr),
      .csr_pwdata              (csr_pwdata),
      .csr_prdata              (csr_prdata),
      .csr_pready              (csr_pready)
   );

endmodule
